@@ design/prht_pkg.sv @@
// Shared widths, types and register indexes for the polyline rectangle hit test.
// No dependencies; used by the top level and its checker.
`default_nettype none

package prht_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIM_BITS    = 15;
  localparam int WIDE_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int EDGE_W      = WIDE_BITS + 2;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int OFF_W       = EDGE_W + 1;
  localparam int PROD_W      = DIFF_W + OFF_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = WIDE_BITS;

  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_DROP_BIT = 0;
  localparam int OUT_HIT_BIT  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = CFG_IDX_W'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic        [DIM_BITS-1:0]   dim_t;

  // Operands of one side test after sign normalization.
  typedef struct packed {
    logic                     ok;
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] dx;
    logic signed [OFF_W-1:0]  n;
    logic signed [OFF_W-1:0]  lo_off;
    logic signed [OFF_W-1:0]  hi_off;
  } side_prep_t;

  typedef struct packed {
    logic                     ok;
    logic signed [PROD_W-1:0] p_lo;
    logic signed [PROD_W-1:0] p_mid;
    logic signed [PROD_W-1:0] p_hi;
  } side_prod_t;

endpackage

`default_nettype wire

@@ design/polyline_rect_hit_test.sv @@
// Top level of the polyline rectangle hit test: stroke state, side tests, stream ports.
// Depends on prht_pkg.
//
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) sets the
//   selection rectangle: index 0 left, 1 top, 2 width, 3 height. Always ready;
//   write only while no points are in flight.
//   Input stream s_axis_*: one stroke point per transaction, tuser = new_stroke.
//   Output stream m_axis_*: one result per input point, in order.
//   Path: input register, then result register, whose valid flag is m_axis_tvalid.
//   Throughput: one point per cycle while m_axis_tready is high; drop test, box,
//   point test and the four side tests all settle between the two registers.
//   Backpressure: the input register holds while the result register is full and
//   stalled; s_axis_tready falls only when both are full and m_axis_tready is low.
//   No transaction is lost or repeated.
//   Reset: rectangle, stroke state, box and hit flag all clear to zero and both
//   registers empty.
`default_nettype none

module polyline_rect_hit_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [prht_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [prht_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y, zero pad
  input  logic [prht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // new_stroke
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // box_min_x, box_max_x, box_min_y, box_max_y, zero pad
  output logic [prht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // point_dropped, any_hit
  output logic [prht_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

  localparam int CW = prht_pkg::COORD_BITS;

  // Configuration
  prht_pkg::coord_t rect_left_q, rect_top_q;
  prht_pkg::dim_t   rect_width_q, rect_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        prht_pkg::REG_RECT_LEFT:   rect_left_q   <= cfg_data_i[CW-1:0];
        prht_pkg::REG_RECT_TOP:    rect_top_q    <= cfg_data_i[CW-1:0];
        prht_pkg::REG_RECT_WIDTH:  rect_width_q  <= cfg_data_i[prht_pkg::DIM_BITS-1:0];
        prht_pkg::REG_RECT_HEIGHT: rect_height_q <= cfg_data_i[prht_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  prht_pkg::edge_t edge_l, edge_r, edge_t_, edge_b;

  always_comb begin
    edge_l  = prht_pkg::EDGE_W'(rect_left_q);
    edge_t_ = prht_pkg::EDGE_W'(rect_top_q);
    edge_r  = edge_l  + $signed(prht_pkg::EDGE_W'(rect_width_q));
    edge_b  = edge_t_ + $signed(prht_pkg::EDGE_W'(rect_height_q));
  end

  // Handshake: input register, then result register
  logic v1_q, v2_q;
  logic r1, r2, out_load;

  assign r2 = !v2_q || m_axis_tready;
  assign r1 = !v1_q || r2;
  assign s_axis_tready = r1;
  assign out_load = r2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) v1_q <= s_axis_tvalid;
      if (r2) v2_q <= v1_q;
    end
  end

  // Input register
  prht_pkg::coord_t s1_x_q, s1_y_q;
  logic             s1_ns_q;

  always_ff @(posedge clk_i) begin
    if (r1 && s_axis_tvalid) begin
      s1_x_q  <= s_axis_tdata[CW-1:0];
      s1_y_q  <= s_axis_tdata[2*CW-1:CW];
      s1_ns_q <= s_axis_tuser;
    end
  end

  // Stroke state, point test, side tests
  prht_pkg::coord_t prev_x_q, prev_y_q;
  logic             have_prev_q;
  prht_pkg::coord_t bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
  prht_pkg::coord_t bmin_x_d, bmax_x_d, bmin_y_d, bmax_y_d;
  logic             out_drop_q, out_hit_q;
  logic             hp, same, pin_d, seg_en;
  prht_pkg::edge_t  xe, ye;

  function automatic prht_pkg::side_prep_t prep_side(
    prht_pkg::coord_t ax, prht_pkg::coord_t aa, prht_pkg::coord_t bx, prht_pkg::coord_t ba,
    prht_pkg::edge_t fixed, prht_pkg::edge_t lo, prht_pkg::edge_t hi, logic en);
    prht_pkg::side_prep_t            sp;
    logic signed [prht_pkg::DIFF_W-1:0] d;
    logic signed [prht_pkg::OFF_W-1:0]  n;
    d = prht_pkg::DIFF_W'(ba) - prht_pkg::DIFF_W'(aa);
    n = prht_pkg::OFF_W'(fixed) - prht_pkg::OFF_W'(aa);
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    sp.ok     = en && (d != '0) && (lo != hi) && (n >= 0) && (n <= prht_pkg::OFF_W'(d));
    sp.d      = d;
    sp.dx     = prht_pkg::DIFF_W'(bx) - prht_pkg::DIFF_W'(ax);
    sp.n      = n;
    sp.lo_off = prht_pkg::OFF_W'(lo) - prht_pkg::OFF_W'(ax);
    sp.hi_off = prht_pkg::OFF_W'(hi) - prht_pkg::OFF_W'(ax);
    return sp;
  endfunction

  prht_pkg::side_prep_t side_d [4];

  always_comb begin
    hp   = have_prev_q && !s1_ns_q;
    same = hp && (s1_x_q == prev_x_q) && (s1_y_q == prev_y_q);
    seg_en = hp && !same;

    xe = prht_pkg::EDGE_W'(s1_x_q);
    ye = prht_pkg::EDGE_W'(s1_y_q);
    pin_d = !same && (xe >= edge_l) && (xe <= edge_r) && (ye >= edge_t_) && (ye <= edge_b);

    if (!hp) begin
      bmin_x_d = s1_x_q;
      bmax_x_d = s1_x_q;
      bmin_y_d = s1_y_q;
      bmax_y_d = s1_y_q;
    end else begin
      bmin_x_d = (s1_x_q < bmin_x_q) ? s1_x_q : bmin_x_q;
      bmax_x_d = (s1_x_q > bmax_x_q) ? s1_x_q : bmax_x_q;
      bmin_y_d = (s1_y_q < bmin_y_q) ? s1_y_q : bmin_y_q;
      bmax_y_d = (s1_y_q > bmax_y_q) ? s1_y_q : bmax_y_q;
    end

    side_d[0] = prep_side(prev_x_q, prev_y_q, s1_x_q, s1_y_q, edge_t_, edge_l, edge_r, seg_en);
    side_d[1] = prep_side(prev_x_q, prev_y_q, s1_x_q, s1_y_q, edge_b, edge_l, edge_r, seg_en);
    side_d[2] = prep_side(prev_y_q, prev_x_q, s1_y_q, s1_x_q, edge_l, edge_t_, edge_b, seg_en);
    side_d[3] = prep_side(prev_y_q, prev_x_q, s1_y_q, s1_x_q, edge_r, edge_t_, edge_b, seg_en);
  end

  prht_pkg::side_prod_t side_p [4];
  logic                 hit_new, hit_d;

  always_comb begin
    hit_new = pin_d;
    for (int i = 0; i < 4; i++) begin
      side_p[i].ok    = side_d[i].ok;
      side_p[i].p_lo  = side_d[i].d  * side_d[i].lo_off;
      side_p[i].p_mid = side_d[i].dx * side_d[i].n;
      side_p[i].p_hi  = side_d[i].d  * side_d[i].hi_off;
      if (side_p[i].ok && (side_p[i].p_lo <= side_p[i].p_mid) &&
          (side_p[i].p_mid <= side_p[i].p_hi)) begin
        hit_new = 1'b1;
      end
    end
    hit_d = (s1_ns_q ? 1'b0 : out_hit_q) || hit_new;
  end

  // Result register; box and hit flag double as stroke state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      bmin_x_q    <= '0;
      bmax_x_q    <= '0;
      bmin_y_q    <= '0;
      bmax_y_q    <= '0;
      out_drop_q  <= 1'b0;
      out_hit_q   <= 1'b0;
    end else if (out_load) begin
      out_drop_q <= same;
      out_hit_q  <= hit_d;
      if (!same) begin
        prev_x_q    <= s1_x_q;
        prev_y_q    <= s1_y_q;
        have_prev_q <= 1'b1;
        bmin_x_q    <= bmin_x_d;
        bmax_x_q    <= bmax_x_d;
        bmin_y_q    <= bmin_y_d;
        bmax_y_q    <= bmax_y_d;
      end
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = prht_pkg::OUT_TDATA_W'({bmax_y_q, bmin_y_q, bmax_x_q, bmin_x_q});
  assign m_axis_tuser  = {out_hit_q, out_drop_q};

endmodule

`default_nettype wire

@@ design/prht_checker.sv @@
// Port-level checker for polyline_rect_hit_test, attached by the bind below.
// Depends on prht_pkg.
`default_nettype none

module prht_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [prht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [prht_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int CW = prht_pkg::COORD_BITS;

  prht_pkg::coord_t min_x, max_x, min_y, max_y;
  logic             out_xfer;

  assign min_x    = m_axis_tdata[CW-1:0];
  assign max_x    = m_axis_tdata[2*CW-1:CW];
  assign min_y    = m_axis_tdata[3*CW-1:2*CW];
  assign max_y    = m_axis_tdata[4*CW-1:3*CW];
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  logic                       seen_q, last_hit_q;
  logic [4*CW-1:0]            last_box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_hit_q <= 1'b0;
      last_box_q <= '0;
    end else if (out_xfer) begin
      seen_q     <= 1'b1;
      last_hit_q <= m_axis_tuser[prht_pkg::OUT_HIT_BIT];
      last_box_q <= m_axis_tdata[4*CW-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("bounding box min above max");

  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tuser[prht_pkg::OUT_DROP_BIT] && seen_q |->
      (m_axis_tuser[prht_pkg::OUT_HIT_BIT] == last_hit_q) &&
      (m_axis_tdata[4*CW-1:0] == last_box_q))
    else $error("dropped point changed hit flag or box");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output side can move");

endmodule

bind polyline_rect_hit_test prht_checker u_prht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
